@@ rtl/mbd_pkg.sv @@
// Shared constants and types for the 2x2 mip-level downsampler.
package mbd_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int PIX_W      = 8;
    localparam int PAIR_W     = 9;
    localparam int CFG_W_W    = 12;
    localparam int CFG_H_W    = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // One accepted word that yields a result, on its way to the output register.
    typedef struct packed {
        logic              exact;
        logic              last;
        logic [PAIR_W-1:0] pair_sum;
        logic [PIX_W-1:0]  pixel;
    } s1_word_t;

endpackage

@@ rtl/mipmap_box_downsample_2x2_top.sv @@
// Top level of the 2x2 box-filter mip-level downsampler.
//
//  channel  direction  ports                            word
//  -------  ---------  -------------------------------  -----------------------------
//  s_       in         s_valid s_ready s_pixel_in       one source pixel, row-major
//  m_       out        m_valid m_ready m_pixel_out      one pixel of the next level
//                      m_last_out                       (last pixel of the level)
//  cfg_     in         cfg_wr_en cfg_wr_index           image_width (0), image_height (1)
//                      cfg_wr_data
//
//  One word is accepted per clock while s_ready is high; a result shows on m_
//  after its source word has passed the stage register, then the result register.
//  The pair-sum line memory (MAX_WIDTH/2 entries) is read once per accepted
//  word and written on odd columns of even rows in exact mode.
//  Reset clears counters, valids and dimensions (2x2); line memory is not cleared.
//  A stall on m_ready backs up through the stage register; s_ready drops only
//  when both the stage and result registers hold words.
module mipmap_box_downsample_2x2_top #(
    parameter int MAX_WIDTH  = mbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mbd_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [mbd_pkg::PIX_W-1:0]      s_pixel_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [mbd_pkg::PIX_W-1:0]      m_pixel_out,
    output logic                           m_last_out,
    input  logic                           cfg_wr_en,
    input  logic [mbd_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [mbd_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    localparam int W_W   = $clog2(MAX_WIDTH+1);
    localparam int H_W   = $clog2(MAX_HEIGHT+1);
    localparam int TOT_W = $clog2((MAX_WIDTH/2)*(MAX_HEIGHT/2)+1);

    // Clamped dims and derived mode; user keeps them stable between images (unenforced)
    logic [W_W-1:0]   width;
    logic [H_W-1:0]   height;
    logic             exact;
    logic [TOT_W-1:0] total;

    // Stage register between the scan logic and the result register
    logic                       s1_valid;
    logic                       s1_take;
    mbd_pkg::s1_word_t          s1_word;
    logic [mbd_pkg::PAIR_W-1:0] line_data;

    mbd_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .width        (width),
        .height       (height),
        .exact        (exact),
        .total        (total)
    );

    // Advance raster position, keep even-row pair sums, decide on a result
    mbd_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_pixel_in (s_pixel_in),
        .width      (width),
        .height     (height),
        .exact      (exact),
        .total      (total),
        .s1_take    (s1_take),
        .s1_valid   (s1_valid),
        .s1_word    (s1_word),
        .line_data  (line_data)
    );

    // Form the averaged or passed pixel and hold it until taken
    mbd_out u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s1_valid    (s1_valid),
        .s1_word     (s1_word),
        .line_data   (line_data),
        .s1_take     (s1_take),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel_out (m_pixel_out),
        .m_last_out  (m_last_out)
    );

    // Input must back off whenever the stage register cannot drain
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid && !s1_take) |-> !s_ready)
        else $error("input accepted while stage register is blocked");

    // A stage word that drains must appear on the result port next cycle
    a_stage_reaches_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid && s1_take) |=> m_valid)
        else $error("stage word lost on its way to the result register");

    // Reset empties both pipeline registers
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && !s1_valid))
        else $error("pipeline not empty after reset");

endmodule

@@ rtl/mbd_cfg.sv @@
// Dimension registers with clamped values, mode and output pixel count.
module mbd_cfg #(
    parameter int MAX_WIDTH  = mbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mbd_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [mbd_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [mbd_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output logic [$clog2(MAX_WIDTH+1)-1:0] width,
    output logic [$clog2(MAX_HEIGHT+1)-1:0] height,
    output logic                           exact,
    output logic [$clog2((MAX_WIDTH/2)*(MAX_HEIGHT/2)+1)-1:0] total
);
    localparam int W_W   = $clog2(MAX_WIDTH+1);
    localparam int H_W   = $clog2(MAX_HEIGHT+1);
    localparam int TOT_W = $clog2((MAX_WIDTH/2)*(MAX_HEIGHT/2)+1);

    logic [W_W-1:0]   w_reg, w_next;
    logic [H_W-1:0]   h_reg, h_next;
    logic             exact_reg, exact_next;
    logic [TOT_W-1:0] total_reg, total_next;
    logic [31:0]      w_raw, h_raw, w_clamp, h_clamp, nw, nh;

    always_comb begin
        w_raw   = 32'(cfg_wr_data[mbd_pkg::CFG_W_W-1:0]);
        h_raw   = 32'(cfg_wr_data[mbd_pkg::CFG_H_W-1:0]);
        w_clamp = (w_raw == 32'd0) ? 32'd1 :
                  (w_raw > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : w_raw;
        h_clamp = (h_raw == 32'd0) ? 32'd1 :
                  (h_raw > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : h_raw;
        w_next = w_reg;
        h_next = h_reg;
        if (cfg_wr_en && cfg_wr_index == mbd_pkg::REG_IMAGE_WIDTH) begin
            w_next = W_W'(w_clamp);
        end
        if (cfg_wr_en && cfg_wr_index == mbd_pkg::REG_IMAGE_HEIGHT) begin
            h_next = H_W'(h_clamp);
        end
        nw = 32'(w_next >> 1);
        nh = 32'(h_next >> 1);
        if (nw == 32'd0) begin
            nw = 32'd1;
        end
        if (nh == 32'd0) begin
            nh = 32'd1;
        end
        exact_next = (nw * 32'd2 == 32'(w_next)) && (nh * 32'd2 == 32'(h_next));
        total_next = TOT_W'(nw[15:0] * nh[15:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg     <= W_W'(2);
            h_reg     <= H_W'(2);
            exact_reg <= 1'b1;
            total_reg <= TOT_W'(1);
        end else begin
            w_reg     <= w_next;
            h_reg     <= h_next;
            exact_reg <= exact_next;
            total_reg <= total_next;
        end
    end

    assign width  = w_reg;
    assign height = h_reg;
    assign exact  = exact_reg;
    assign total  = total_reg;

endmodule

@@ rtl/mbd_scan.sv @@
// Raster counters, pair-sum line memory and the first pipeline register.
module mbd_scan #(
    parameter int MAX_WIDTH  = mbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mbd_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [mbd_pkg::PIX_W-1:0]        s_pixel_in,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]   width,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]  height,
    input  logic                             exact,
    input  logic [$clog2((MAX_WIDTH/2)*(MAX_HEIGHT/2)+1)-1:0] total,
    input  logic                             s1_take,
    output logic                             s1_valid,
    output mbd_pkg::s1_word_t                s1_word,
    output logic [mbd_pkg::PAIR_W-1:0]       line_data
);
    localparam int W_W   = $clog2(MAX_WIDTH+1);
    localparam int H_W   = $clog2(MAX_HEIGHT+1);
    localparam int TOT_W = $clog2((MAX_WIDTH/2)*(MAX_HEIGHT/2)+1);
    localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [COL_W-1:0]          col_reg;
    logic [ROW_W-1:0]          row_reg;
    logic [TOT_W-1:0]          cnt_reg, cnt_inc;
    logic [mbd_pkg::PIX_W-1:0] even_reg;
    logic                      s1_valid_reg;
    mbd_pkg::s1_word_t         s1_word_reg, s1_word_next;
    logic [mbd_pkg::PAIR_W-1:0] line_reg;
    logic [mbd_pkg::PAIR_W-1:0] pair_mem [DEPTH];

    logic                      fire, row_end, img_end, emit, mem_we;
    logic [mbd_pkg::PAIR_W-1:0] pair;
    logic [AW-1:0]             addr;

    assign s_ready = !s1_valid_reg || s1_take;
    assign fire    = s_valid && s_ready;

    always_comb begin
        row_end = (32'(col_reg) + 32'd1 >= 32'(width));
        img_end = row_end && (32'(row_reg) + 32'd1 >= 32'(height));
        pair    = {1'b0, even_reg} + {1'b0, s_pixel_in};
        cnt_inc = cnt_reg + TOT_W'(1);
        addr    = AW'(col_reg >> 1);
        mem_we  = exact && col_reg[0] && !row_reg[0];
        emit    = exact ? (col_reg[0] && row_reg[0]) : (cnt_reg < total);
        s1_word_next.exact    = exact;
        s1_word_next.last     = exact ? img_end : (cnt_inc == total);
        s1_word_next.pair_sum = pair;
        s1_word_next.pixel    = s_pixel_in;
    end

    // Line memory: write the even-row pair, read the slot for the odd row.
    always_ff @(posedge aclk) begin
        if (fire) begin
            if (mem_we) begin
                pair_mem[addr] <= pair;
            end
            line_reg <= pair_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            s1_word_reg <= s1_word_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            cnt_reg      <= '0;
            even_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                s1_valid_reg <= emit;
                if (exact && !col_reg[0]) begin
                    even_reg <= s_pixel_in;
                end
                if (img_end) begin
                    col_reg <= '0;
                    row_reg <= '0;
                    cnt_reg <= '0;
                end else begin
                    if (emit) begin
                        cnt_reg <= cnt_inc;
                    end
                    if (row_end) begin
                        col_reg <= '0;
                        row_reg <= row_reg + ROW_W'(1);
                    end else begin
                        col_reg <= col_reg + COL_W'(1);
                    end
                end
            end else if (s1_take) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    assign s1_valid  = s1_valid_reg;
    assign s1_word   = s1_word_reg;
    assign line_data = line_reg;

endmodule

@@ rtl/mbd_out.sv @@
// Box average or pass-through select into the result register.
module mbd_out (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s1_valid,
    input  mbd_pkg::s1_word_t            s1_word,
    input  logic [mbd_pkg::PAIR_W-1:0]   line_data,
    output logic                         s1_take,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [mbd_pkg::PIX_W-1:0]    m_pixel_out,
    output logic                         m_last_out
);
    logic                          valid_reg;
    logic [mbd_pkg::PIX_W-1:0]     pixel_reg, pixel_next;
    logic                          last_reg;
    logic [mbd_pkg::PAIR_W:0]      box_sum;

    assign s1_take = !valid_reg || m_ready;

    always_comb begin
        box_sum    = {1'b0, line_data} + {1'b0, s1_word.pair_sum};
        pixel_next = s1_word.exact ? box_sum[mbd_pkg::PAIR_W:2] : s1_word.pixel;
    end

    always_ff @(posedge aclk) begin
        if (s1_valid && s1_take) begin
            pixel_reg <= pixel_next;
            last_reg  <= s1_word.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s1_take) begin
            valid_reg <= s1_valid;
        end
    end

    assign m_valid     = valid_reg;
    assign m_pixel_out = pixel_reg;
    assign m_last_out  = last_reg;

endmodule

@@ tb/mipmap_box_downsample_2x2_top_test.sv @@
// Self-checking testbench for the 2x2 box-filter mip-level downsampler.
`timescale 1ns / 1ps

module mipmap_box_downsample_2x2_top_test;

    localparam int MAX_W       = mbd_pkg::DEF_MAX_WIDTH;
    localparam int MAX_H       = mbd_pkg::DEF_MAX_HEIGHT;
    localparam int LINE_DEPTH  = MAX_W / 2;
    localparam int PX_W        = mbd_pkg::PIX_W;
    localparam int DATA_W      = mbd_pkg::CFG_DATA_W;
    localparam int HALF_PERIOD = 2;
    localparam int DRAIN_GAP   = 8;   // stage + result register, with margin
    localparam int TAIL_WAIT   = 16;
    localparam int PLAN_LEN    = 34;
    localparam int RAND_QUOTA  = 340;

    // Index with no register behind it; a write there must change nothing.
    localparam logic [mbd_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [mbd_pkg::PIX_W-1:0] px;
        logic                      last;
    } level_word_t;

    // One row of the directed plan: a register write or a source pixel, the
    // latter with an optional hand-typed result.
    typedef struct packed {
        bit                             is_cfg;
        logic [mbd_pkg::CFG_IDX_W-1:0]  idx;
        logic [mbd_pkg::CFG_DATA_W-1:0] val;
        logic [mbd_pkg::PIX_W-1:0]      px;
        bit                             typed;
        logic [mbd_pkg::PIX_W-1:0]      exp_px;
        bit                             exp_last;
    } plan_row_t;

    logic                           aclk         = 1'b0;
    logic                           aresetn      = 1'b0;
    logic                           s_valid      = 1'b0;
    logic                           s_ready;
    logic [mbd_pkg::PIX_W-1:0]      s_pixel_in   = '0;
    logic                           m_valid;
    logic                           m_ready      = 1'b0;
    logic [mbd_pkg::PIX_W-1:0]      m_pixel_out;
    logic                           m_last_out;
    logic                           cfg_wr_en    = 1'b0;
    logic [mbd_pkg::CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [mbd_pkg::CFG_DATA_W-1:0] cfg_wr_data  = '0;

    // Predictor copy of the block: dimensions, line of pair sums, counters.
    logic [mbd_pkg::CFG_W_W-1:0]  dim_w;
    logic [mbd_pkg::CFG_H_W-1:0]  dim_h;
    logic [mbd_pkg::PAIR_W-1:0]   pair_line [0:LINE_DEPTH-1];
    logic [mbd_pkg::PIX_W-1:0]    even_px;
    logic [10:0]                  col_pos;
    logic [11:0]                  row_pos;
    logic [21:0]                  emit_cnt;

    level_word_t level_q [$];     // next-level pixels still owed by the block
    plan_row_t   plan [0:PLAN_LEN-1];
    int          mismatch_count = 0;
    int          s_idle_pct     = 0;
    int          m_idle_pct     = 0;

    mipmap_box_downsample_2x2_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel_in  (s_pixel_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel_out (m_pixel_out),
        .m_last_out  (m_last_out),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // A register value of zero counts as one; oversized values saturate.
    function automatic int fit_dim(input int v, input int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advance the predictor by one accepted source pixel and say whether it
    // completes a pixel of the next level.
    function automatic void next_level_pixel(input logic [mbd_pkg::PIX_W-1:0] p,
                                             output bit got, output level_word_t res);
        int w, h, nw, nh, col, row, pair, total, sum;
        bit row_end, img_end;
        w = fit_dim(dim_w, MAX_W);
        h = fit_dim(dim_h, MAX_H);
        nw = (w >> 1) < 1 ? 1 : (w >> 1);
        nh = (h >> 1) < 1 ? 1 : (h >> 1);
        col = col_pos;
        row = row_pos;
        got = 1'b0;
        res = '0;
        row_end = (col + 1 >= w);
        img_end = row_end && (row + 1 >= h);
        if (nw * 2 == w && nh * 2 == h) begin
            // Exact halving: pair sums on even rows, 2x2 average on odd rows.
            if (col % 2 == 0) begin
                even_px = p;
            end else begin
                pair = even_px + p;
                if ((col >> 1) < LINE_DEPTH) begin
                    if (row % 2 == 0) begin
                        pair_line[col >> 1] = pair[mbd_pkg::PAIR_W-1:0];
                    end else begin
                        sum = (pair_line[col >> 1] + pair) >> 2;
                        res.px = sum[mbd_pkg::PIX_W-1:0];
                        res.last = img_end;
                        emit_cnt = emit_cnt + 1'b1;
                        got = 1'b1;
                    end
                end
            end
        end else begin
            // Pass-through: the first nw*nh source pixels leave unchanged.
            total = nw * nh;
            if (int'(emit_cnt) < total) begin
                emit_cnt = emit_cnt + 1'b1;
                res.px = p;
                res.last = (int'(emit_cnt) == total);
                got = 1'b1;
            end
        end
        if (img_end) begin
            col_pos = '0;
            row_pos = '0;
            emit_cnt = '0;
        end else if (row_end) begin
            col_pos = '0;
            row_pos = row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end
    endfunction

    function automatic plan_row_t pix(input logic [mbd_pkg::PIX_W-1:0] p);
        return '{1'b0, '0, '0, p, 1'b0, '0, 1'b0};
    endfunction

    function automatic plan_row_t pix_chk(input logic [mbd_pkg::PIX_W-1:0] p,
                                          input logic [mbd_pkg::PIX_W-1:0] e,
                                          input bit l);
        return '{1'b0, '0, '0, p, 1'b1, e, l};
    endfunction

    function automatic plan_row_t reg_wr(input logic [mbd_pkg::CFG_IDX_W-1:0] i,
                                         input logic [mbd_pkg::CFG_DATA_W-1:0] v);
        return '{1'b1, i, v, '0, 1'b0, '0, 1'b0};
    endfunction

    // Drop valid and hold until every owed word is out and the pipe is empty.
    task automatic hold_until_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (level_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [mbd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mbd_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_wr_index = idx;
        cfg_wr_data = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        if (idx == mbd_pkg::REG_IMAGE_WIDTH) begin
            dim_w = val[mbd_pkg::CFG_W_W-1:0];
        end else if (idx == mbd_pkg::REG_IMAGE_HEIGHT) begin
            dim_h = val;
        end
    endtask

    task automatic set_dims(input int w, input int h);
        hold_until_drained();
        write_reg(mbd_pkg::REG_IMAGE_WIDTH, DATA_W'(w));
        write_reg(mbd_pkg::REG_IMAGE_HEIGHT, DATA_W'(h));
    endtask

    // Present one source word, idling first at the sender's rate, and log the
    // owed result once the word is taken. A typed result overrides the predictor.
    task automatic feed_pixel(input logic [mbd_pkg::PIX_W-1:0] p, input bit typed,
                              input level_word_t typed_word, output bit was_last);
        bit got;
        level_word_t res;
        @(negedge aclk);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_pixel_in = p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        next_level_pixel(p, got, res);
        if (typed) begin
            res = typed_word;
            got = 1'b1;
        end
        if (got) level_q.push_back(res);
        was_last = got && res.last;
    endtask

    task automatic feed_run(input int n);
        bit lst;
        for (int i = 0; i < n; i++) begin
            // Now and then let the pipe run dry mid-image.
            if ($urandom_range(0, 199) == 0) hold_until_drained();
            feed_pixel(PX_W'($urandom_range(0, 255)), 1'b0, '0, lst);
        end
    endtask

    // Abort a partial image: a 1x1 level ends it on the next word.
    task automatic close_image();
        bit lst;
        if (col_pos != 0 || row_pos != 0) begin
            set_dims(1, 1);
            feed_pixel(PX_W'($urandom_range(0, 255)), 1'b0, '0, lst);
        end
    endtask

    // Mostly whole exact-halving images; the rest pass-through levels switched
    // in mid-image, with a few raw register values across the full range.
    task automatic run_random(input int quota);
        int done, pick, w, h, n;
        done = 0;
        while (done < quota) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                w = 2 * $urandom_range(1, 8);
                h = 2 * $urandom_range(1, 6);
                close_image();
                set_dims(w, h);
                n = w * h * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0) n += $urandom_range(1, w * h - 1);
            end else if (pick < 9) begin
                w = $urandom_range(0, 15);
                h = $urandom_range(0, 9);
                if (w % 2 == 0 && w != 0 && h % 2 == 0 && h != 0) h = h + 1;
                set_dims(w, h);
                n = $urandom_range(1, 2 * fit_dim(w, MAX_W) * fit_dim(h, MAX_H) + 3);
            end else begin
                w = $urandom_range(0, 8191);
                h = $urandom_range(0, 8191);
                if (fit_dim(w % 4096, MAX_W) % 2 == 0 && fit_dim(h, MAX_H) % 2 == 0) begin
                    h = $urandom_range(0, 4095) | 1;
                end
                set_dims(w, h);
                n = $urandom_range(1, 40);
            end
            // Stay within the item budget for this phase.
            if (n > quota - done) n = quota - done;
            feed_run(n);
            done += n;
        end
    endtask

    // Receiver: stall at random on the falling edge.
    initial begin
        forever begin
            @(negedge aclk);
            m_ready = ($urandom_range(0, 99) >= m_idle_pct);
        end
    end

    // Compare every taken result word with the oldest owed pixel.
    always @(posedge aclk) begin : check_level_word
        level_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (level_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected word, expected none, got pixel %0d last %0b",
                         $time, m_pixel_out, m_last_out);
            end else begin
                want = level_q.pop_front();
                if (m_pixel_out !== want.px) begin
                    mismatch_count++;
                    $display("%0t: pixel_out expected %0d, got %0d",
                             $time, want.px, m_pixel_out);
                end
                if (m_last_out !== want.last) begin
                    mismatch_count++;
                    $display("%0t: last_out expected %0b, got %0b",
                             $time, want.last, m_last_out);
                end
            end
        end
    end

    initial begin
        bit lst;
        level_word_t tw;

        dim_w = 12'd2;
        dim_h = 13'd2;
        even_px = '0;
        col_pos = '0;
        row_pos = '0;
        emit_cnt = '0;
        for (int i = 0; i < LINE_DEPTH; i++) pair_line[i] = '0;

        plan = '{
            // 2x2 after reset: flat white, then flat black
            pix(8'd255), pix(8'd255), pix(8'd255), pix_chk(8'd255, 8'd255, 1'b1),
            pix(8'd0), pix(8'd0), pix(8'd0), pix_chk(8'd0, 8'd0, 1'b1),
            // write to an unmapped index, then a mixed 2x2 block
            reg_wr(REG_SPARE, 13'h1FFF),
            pix(8'd1), pix(8'd2), pix(8'd3), pix(8'd4),
            // 1x1 image passes its pixel through as the last one
            reg_wr(mbd_pkg::REG_IMAGE_WIDTH, 13'd1), reg_wr(mbd_pkg::REG_IMAGE_HEIGHT, 13'd1),
            pix_chk(8'hA5, 8'hA5, 1'b1),
            // zero dimensions act as one
            reg_wr(mbd_pkg::REG_IMAGE_WIDTH, 13'd0), reg_wr(mbd_pkg::REG_IMAGE_HEIGHT, 13'd0),
            pix_chk(8'h5A, 8'h5A, 1'b1),
            // odd width: first pixel out, the rest silent
            reg_wr(mbd_pkg::REG_IMAGE_WIDTH, 13'd3), reg_wr(mbd_pkg::REG_IMAGE_HEIGHT, 13'd1),
            pix_chk(8'h81, 8'h81, 1'b1), pix(8'h7E), pix(8'h3C),
            // 4x2 with carries through the pair sum
            reg_wr(mbd_pkg::REG_IMAGE_WIDTH, 13'd4), reg_wr(mbd_pkg::REG_IMAGE_HEIGHT, 13'd2),
            pix(8'd200), pix(8'd255), pix(8'd17), pix(8'd3),
            pix(8'd255), pix(8'd254), pix(8'd0), pix(8'd1)
        };

        // Hold reset, then release it on a falling edge.
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Sender idles lightly, receiver heavily.
        s_idle_pct = 14;
        m_idle_pct = 53;

        for (int i = 0; i < PLAN_LEN; i++) begin
            if (plan[i].is_cfg) begin
                hold_until_drained();
                write_reg(plan[i].idx, plan[i].val);
            end else begin
                tw.px = plan[i].exp_px;
                tw.last = plan[i].exp_last;
                feed_pixel(plan[i].px, plan[i].typed, tw, lst);
            end
        end

        run_random(RAND_QUOTA);

        // Swap the idling sides.
        s_idle_pct = 53;
        m_idle_pct = 14;
        run_random(RAND_QUOTA);

        // No idling on either side.
        s_idle_pct = 0;
        m_idle_pct = 0;
        run_random(RAND_QUOTA);

        hold_until_drained();
        repeat (TAIL_WAIT) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("mipmap_box_downsample_2x2_top: match");
        end else begin
            $display("mipmap_box_downsample_2x2_top: mismatch");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #(4_000_000);
        $display("mipmap_box_downsample_2x2_top: mismatch");
        $finish;
    end

endmodule
